>>> hw/rtl/biphasic_temporal_pixel_filter_assert.svh
// Assertion macros for the biphasic temporal pixel filter.
// All checks run on clk_i and are off while rst_ni is low.
`ifndef BIPHASIC_TEMPORAL_PIXEL_FILTER_ASSERT_SVH
`define BIPHASIC_TEMPORAL_PIXEL_FILTER_ASSERT_SVH

// Same-cycle implication.
`define BTPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/btpf_pkg.sv
`timescale 1ns / 1ps

package btpf_pkg;

  localparam int PIX_W          = 8;
  localparam int ALPHA_W        = 16;
  localparam int GAIN_W         = 16;
  localparam int GAIN_SHIFT     = 15;
  localparam int GAIN_ONE       = 32768;
  localparam int ALPHA_RST      = 26214;
  localparam int FRAME_SIZE_RST = 524288;
  localparam int NUM_LANES      = 3;
  localparam int OFIFO_DEPTH    = 8;

  // signed width for 3*a - 2*one
  localparam int GSUM_W = ALPHA_W + 3;

  typedef logic [GAIN_W-1:0] gain_t;
  // index 0: a, 1: 2a-1, 2: 3a-2
  typedef logic [NUM_LANES-1:0][GAIN_W-1:0] gains_t;

  function automatic gain_t clamp_gain(logic signed [GSUM_W-1:0] v);
    gain_t g;
    logic signed [GSUM_W-1:0] one_s;
    one_s = GSUM_W'(GAIN_ONE);
    priority if (v < 0) begin
      g = '0;
    end else if (v > one_s) begin
      g = GAIN_W'(GAIN_ONE);
    end else begin
      g = v[GAIN_W-1:0];
    end
    return g;
  endfunction

  function automatic gains_t calc_gains(logic [ALPHA_W-1:0] a);
    gains_t g;
    logic signed [GSUM_W-1:0] a_s;
    logic signed [GSUM_W-1:0] one_s;
    a_s   = $signed({3'b000, a});
    one_s = GSUM_W'(GAIN_ONE);
    g[0]  = clamp_gain(a_s);
    g[1]  = clamp_gain((a_s <<< 1) - one_s);
    g[2]  = clamp_gain(a_s + (a_s <<< 1) - (one_s <<< 1));
    return g;
  endfunction

endpackage

>>> hw/rtl/btpf_store.sv
`timescale 1ns / 1ps

// Frame store: one write port, one read port with registered data.
module btpf_store #(
  parameter int DEPTH = 524288,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hw/rtl/btpf_lane.sv
`timescale 1ns / 1ps

// One exponential smoother: y' = x + (g * (y - x)) >>> 15.
// Stage B: difference, stage C: product, stage D: updated value.
module btpf_lane #(
  parameter int FRAC_W = 8
) (
  input  logic                                clk_i,
  input  logic                                seed_i,
  input  logic [btpf_pkg::PIX_W-1:0]          pix_i,
  input  logic [btpf_pkg::PIX_W+FRAC_W-1:0]   old_i,
  input  btpf_pkg::gain_t                     gain_i,
  output logic [btpf_pkg::PIX_W+FRAC_W-1:0]   ynew_o,
  output logic [btpf_pkg::PIX_W+FRAC_W-1:0]   y_o
);

  import btpf_pkg::*;

  localparam int Y_W = PIX_W + FRAC_W;
  localparam int D_W = Y_W + 1;
  localparam int P_W = D_W + GAIN_W + 1;

  logic [Y_W-1:0]          x_a;
  logic signed [D_W-1:0]   diff_d;
  logic signed [D_W-1:0]   diff_q;
  logic [Y_W-1:0]          xb_q;
  logic signed [P_W-1:0]   prod_q;
  logic [Y_W-1:0]          xc_q;
  logic signed [P_W-1:0]   ysum;
  logic [Y_W-1:0]          y_q;

  assign x_a = {pix_i, {FRAC_W{1'b0}}};

  // seeding: old value is the pixel itself, so the difference is zero
  always_comb begin
    if (seed_i) begin
      diff_d = '0;
    end else begin
      diff_d = $signed({1'b0, old_i}) - $signed({1'b0, x_a});
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    xb_q   <= x_a;
    prod_q <= diff_q * $signed({1'b0, gain_i});
    xc_q   <= xb_q;
    y_q    <= ynew_o;
  end

  // arithmetic shift floors, same as truncating the all-positive form
  assign ysum   = $signed({{(P_W-Y_W){1'b0}}, xc_q}) + (prod_q >>> GAIN_SHIFT);
  assign ynew_o = ysum[Y_W-1:0];
  assign y_o    = y_q;

endmodule

>>> hw/rtl/btpf_resp.sv
`timescale 1ns / 1ps

// Biphasic combination and its square. Stage E: response, stage F: square.
module btpf_resp #(
  parameter int FRAC_W = 8
) (
  input  logic                                          clk_i,
  input  logic [btpf_pkg::PIX_W+FRAC_W-1:0]             y1_i,
  input  logic [btpf_pkg::PIX_W+FRAC_W-1:0]             y2_i,
  input  logic [btpf_pkg::PIX_W+FRAC_W-1:0]             y3_i,
  output logic signed [btpf_pkg::PIX_W+FRAC_W+1:0]      bip_o,
  output logic [2*btpf_pkg::PIX_W+2+FRAC_W-1:0]         energy_o
);

  import btpf_pkg::*;

  localparam int B_W = PIX_W + FRAC_W + 2;
  localparam int E_W = 2 * PIX_W + 2 + FRAC_W;

  logic signed [B_W-1:0]   bip_d;
  logic signed [B_W-1:0]   bip_e_q;
  logic signed [B_W-1:0]   bip_f_q;
  logic signed [2*B_W-1:0] sq_q;

  assign bip_d = $signed({1'b0, y2_i, 1'b0}) - $signed({2'b00, y1_i})
               - $signed({2'b00, y3_i});

  always_ff @(posedge clk_i) begin
    bip_e_q <= bip_d;
    bip_f_q <= bip_e_q;
    sq_q    <= bip_e_q * bip_e_q;
  end

  assign bip_o    = bip_f_q;
  assign energy_o = sq_q[FRAC_W +: E_W];

endmodule

>>> hw/rtl/btpf_ofifo.sv
`timescale 1ns / 1ps

// Output queue; the upstream pipeline is throttled by credit, so a push
// never meets a full queue.
module btpf_ofifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           push_data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [WIDTH-1:0]           data_o,
  output logic [$clog2(DEPTH):0]     count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hw/rtl/biphasic_temporal_pixel_filter.sv
// A result word passes stages A to F and enters the output queue before it is offered.
// Throughput: one pixel per cycle while credit and hazard allow, six pipeline stages plus an 8-word output queue.
// Frames of fewer than 4 pixels stall input until the earlier pixel at the same
// position has written its smoothers back.
// Reset clears control and loads register defaults; the frame store is not
// cleared, the first frame after reset seeds it and yields a zero response.
`timescale 1ns / 1ps

module biphasic_temporal_pixel_filter #(
  parameter int FRAME_PIXELS  = 524288,
  parameter int FRACTION_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,

  // configuration writes
  input  logic cfg_we_i,
  input  logic cfg_idx_i,
  input  logic [((($clog2(FRAME_PIXELS) + 1) > btpf_pkg::ALPHA_W) ?
                 ($clog2(FRAME_PIXELS) + 1) : btpf_pkg::ALPHA_W)-1:0] cfg_data_i,

  // pixel input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [btpf_pkg::PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel_value

  // result output
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // from bit 0 up: bipolar_response, response_energy, pixel_position, zero pad
  output logic [((btpf_pkg::PIX_W + FRACTION_BITS + 2) +
                 (2 * btpf_pkg::PIX_W + 2 + FRACTION_BITS) +
                 $clog2(FRAME_PIXELS) + 7) / 8 * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast                            // frame_end
);

  import btpf_pkg::*;

  // ---------------------------------------------------------------------
  // Widths
  // ---------------------------------------------------------------------
  localparam int POS_W    = $clog2(FRAME_PIXELS);
  localparam int SIZE_W   = POS_W + 1;
  localparam int Y_W      = PIX_W + FRACTION_BITS;        // smoother, Q8.F
  localparam int B_W      = Y_W + 2;                      // response
  localparam int E_W      = 2 * PIX_W + 2 + FRACTION_BITS; // energy
  localparam int OUT_W    = B_W + E_W + POS_W;
  localparam int OUT_TD_W = (OUT_W + 7) / 8 * 8;
  localparam int FIFO_W   = OUT_W + 1;
  localparam int CNT_W    = $clog2(OFIFO_DEPTH) + 1;

  // Pipeline stages: 0 A (store read data), 1 B (difference),
  // 2 C (product, write-back), 3 D (smoothers), 4 E (response), 5 F (square)
  localparam int NSTAGE   = 6;
  localparam int ST_WB    = 2;
  localparam int OCC_W    = $clog2(OFIFO_DEPTH + NSTAGE) + 1;

  localparam int RST_SIZE = (FRAME_SIZE_RST > FRAME_PIXELS) ? FRAME_PIXELS : FRAME_SIZE_RST;
  localparam logic [POS_W-1:0] RST_LIMIT = POS_W'(RST_SIZE - 1);

  typedef enum logic {
    CFG_ALPHA_GAIN = 1'b0,
    CFG_FRAME_SIZE = 1'b1
  } cfg_idx_e;

  // frame size to index of the last pixel: zero acts as one, oversize clamps
  function automatic logic [POS_W-1:0] size_limit(logic [SIZE_W-1:0] s);
    logic [POS_W-1:0] lim;
    logic [SIZE_W-1:0] sm1;
    sm1 = s - 1'b1;
    priority if (s == '0) begin
      lim = '0;
    end else if (s > SIZE_W'(FRAME_PIXELS)) begin
      lim = POS_W'(FRAME_PIXELS - 1);
    end else begin
      lim = sm1[POS_W-1:0];
    end
    return lim;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration: gains and frame limit are derived at write time
  // ---------------------------------------------------------------------
  gains_t           gains_q;
  logic [POS_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= calc_gains(ALPHA_W'(ALPHA_RST));
      limit_q <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_GAIN: gains_q <= calc_gains(cfg_data_i[ALPHA_W-1:0]);
        CFG_FRAME_SIZE: limit_q <= size_limit(cfg_data_i[SIZE_W-1:0]);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input accept, position counter, priming
  // ---------------------------------------------------------------------
  logic             accept;
  logic             last_in;
  logic             hazard;
  logic             credit_ok;
  logic [OCC_W-1:0] occ;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic             primed_q;
  logic [CNT_W-1:0] fifo_count;

  logic             vld_q  [NSTAGE];
  logic [POS_W-1:0] pos_q  [NSTAGE];
  logic             last_q [NSTAGE];
  logic [PIX_W-1:0] a_pix_q;
  logic             a_seed_q;

  // A pixel whose position is still in flight ahead of write-back must wait:
  // its store read would miss that update.
  always_comb begin
    hazard = 1'b0;
    for (int s = 0; s <= ST_WB; s++) begin
      if (vld_q[s] && (pos_q[s] == cnt_q)) begin
        hazard = 1'b1;
      end
    end
  end

  // Credit: words in the pipeline plus words queued never exceed the queue.
  always_comb begin
    occ = OCC_W'(fifo_count);
    for (int s = 0; s < NSTAGE; s++) begin
      occ = occ + OCC_W'(vld_q[s]);
    end
  end

  assign credit_ok     = (occ < OCC_W'(OFIFO_DEPTH));
  assign s_axis_tready = credit_ok && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // a shrunk frame size ends the frame at once
  assign last_in       = (cnt_q >= limit_q);
  assign cnt_d         = last_in ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      primed_q <= 1'b0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      if (last_in) begin
        primed_q <= 1'b1;
      end
    end
  end

  // valid bits of the shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTAGE; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int s = 1; s < NSTAGE; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // payload of the shift line
  always_ff @(posedge clk_i) begin
    pos_q[0]  <= cnt_q;
    last_q[0] <= last_in;
    a_pix_q   <= s_axis_tdata;
    a_seed_q  <= !primed_q;
    for (int s = 1; s < NSTAGE; s++) begin
      pos_q[s]  <= pos_q[s-1];
      last_q[s] <= last_q[s-1];
    end
  end

  // ---------------------------------------------------------------------
  // Frame store: read on accept, write back from stage C
  // ---------------------------------------------------------------------
  logic [NUM_LANES*Y_W-1:0] rd_data;
  logic [NUM_LANES*Y_W-1:0] wr_data;
  logic [Y_W-1:0]           ynew [NUM_LANES];
  logic [Y_W-1:0]           ysm  [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      wr_data[l*Y_W +: Y_W] = ynew[l];
    end
  end

  btpf_store #(
    .DEPTH (FRAME_PIXELS),
    .WIDTH (NUM_LANES * Y_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (vld_q[ST_WB]),
    .wr_addr_i (pos_q[ST_WB]),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (cnt_q),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------
  // Smoothers, gains a, 2a-1, 3a-2
  // ---------------------------------------------------------------------
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    btpf_lane #(
      .FRAC_W (FRACTION_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .seed_i (a_seed_q),
      .pix_i  (a_pix_q),
      .old_i  (rd_data[l*Y_W +: Y_W]),
      .gain_i (gains_q[l]),
      .ynew_o (ynew[l]),
      .y_o    (ysm[l])
    );
  end

  // ---------------------------------------------------------------------
  // Response -y1 + 2*y2 - y3 and its energy
  // ---------------------------------------------------------------------
  logic signed [B_W-1:0] bip;
  logic [E_W-1:0]        energy;

  btpf_resp #(
    .FRAC_W (FRACTION_BITS)
  ) u_resp (
    .clk_i    (clk_i),
    .y1_i     (ysm[0]),
    .y2_i     (ysm[1]),
    .y3_i     (ysm[2]),
    .bip_o    (bip),
    .energy_o (energy)
  );

  // ---------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------
  logic [FIFO_W-1:0] push_data;
  logic [FIFO_W-1:0] fifo_dout;

  assign push_data = {last_q[NSTAGE-1], pos_q[NSTAGE-1], energy, bip};

  btpf_ofifo #(
    .WIDTH (FIFO_W),
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (vld_q[NSTAGE-1]),
    .push_data_i (push_data),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (fifo_dout),
    .count_o     (fifo_count)
  );

  assign m_axis_tdata = OUT_TD_W'(fifo_dout[OUT_W-1:0]);
  assign m_axis_tlast = fifo_dout[OUT_W];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "biphasic_temporal_pixel_filter_assert.svh"

  `BTPF_ASSERT_NOW(a_no_rw_clash, accept && vld_q[ST_WB], pos_q[ST_WB] != cnt_q, "store read and write-back hit the same position")
  `BTPF_ASSERT_NOW(a_credit, 1'b1, occ <= OCC_W'(OFIFO_DEPTH), "pipeline and queue hold more words than the queue depth")
  `BTPF_ASSERT_NOW(a_push_room, vld_q[NSTAGE-1], fifo_count < CNT_W'(OFIFO_DEPTH), "push into a full output queue")
  `BTPF_ASSERT_NEXT(a_frame_wrap, accept && last_in, primed_q && (cnt_q == '0), "frame end did not wrap position and prime store")

endmodule
